// File: hdl/prgate_pkg.sv
package prgate_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned PEER_COUNT_DEFAULT  = 16;
  localparam int unsigned WINDOW_BITS_DEFAULT = 64;

  // Entries in the queue between classifier and state engine
  localparam int unsigned QUEUE_DEPTH = 2;

  // Field widths
  localparam int unsigned PEER_ID_W   = 4;
  localparam int unsigned PROTO_W     = 16;
  localparam int unsigned DICT_W      = 32;
  localparam int unsigned HASH_W      = 64;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned TOKEN_W     = 24;
  localparam int unsigned PROD_W      = TICK_W + TOKEN_W;
  localparam int unsigned VERDICT_W   = 3;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  // Q8.16 token constants
  localparam logic [TOKEN_W-1:0] ONE_TOKEN    = 24'h01_0000;
  localparam logic [TOKEN_W-1:0] BURST_RESET  = 24'h10_0000;
  localparam logic [TOKEN_W-1:0] REFILL_RESET = 24'h01_0000;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PROTOCOL      = 3'd0,
    CFG_CHECK_DICT    = 3'd1,
    CFG_DICT          = 3'd2,
    CFG_CHECK_CONTENT = 3'd3,
    CFG_CONTENT       = 3'd4,
    CFG_BURST         = 3'd5,
    CFG_REFILL        = 3'd6
  } cfg_idx_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_PROTOCOL  = 3'd1,
    VERDICT_DICT      = 3'd2,
    VERDICT_CONTENT   = 3'd3,
    VERDICT_MALFORMED = 3'd4,
    VERDICT_RATE      = 3'd5,
    VERDICT_TOO_OLD   = 3'd6,
    VERDICT_DUP       = 3'd7
  } verdict_e;

  typedef enum logic {
    ACTION_CHECK = 1'b0,
    ACTION_RESET = 1'b1
  } action_e;

  // What the state engine has to do with a queued transaction
  typedef enum logic [1:0] {
    OP_RESET   = 2'd0,
    OP_VERDICT = 2'd1,
    OP_PACKET  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                   op;
    verdict_e              verdict;
    logic [PEER_ID_W-1:0]  peer;
    logic [SEQ_W-1:0]      seq;
    logic [TICK_W-1:0]     now;
  } gate_item_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] burst;
    logic [TOKEN_W-1:0] refill;
  } bucket_cfg_t;

endpackage

// File: hdl/prgate_ram.sv
module prgate_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/prgate_fifo.sv
module prgate_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  prgate_pkg::gate_item_t data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output prgate_pkg::gate_item_t data_o,
  output logic                   empty_o
);

  localparam int unsigned DEPTH = prgate_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = PTR_W + 1;

  prgate_pkg::gate_item_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);

endmodule

// File: hdl/prgate_front.sv
module prgate_front (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // packet channel
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     action_i,
  input  logic [prgate_pkg::PEER_ID_W-1:0]         peer_id_i,
  input  logic [prgate_pkg::PROTO_W-1:0]           pkt_protocol_i,
  input  logic [prgate_pkg::DICT_W-1:0]            pkt_dictionary_i,
  input  logic [prgate_pkg::HASH_W-1:0]            pkt_content_hash_i,
  input  logic [prgate_pkg::SEQ_W-1:0]             seq_number_i,
  input  logic [prgate_pkg::TICK_W-1:0]            now_tick_i,
  // configuration channel
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [prgate_pkg::CFG_INDEX_W-1:0]       cfg_index_i,
  input  logic [prgate_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // toward the queue and state engine
  input  logic                                     clearing_i,
  input  logic                                     full_i,
  output logic                                     push_o,
  output prgate_pkg::gate_item_t                   item_o,
  output prgate_pkg::bucket_cfg_t                  bucket_cfg_o
);

  logic [prgate_pkg::PROTO_W-1:0] proto_q;
  logic                           check_dict_q;
  logic [prgate_pkg::DICT_W-1:0]  dict_q;
  logic                           check_content_q;
  logic [prgate_pkg::HASH_W-1:0]  content_q;
  logic [prgate_pkg::TOKEN_W-1:0] burst_q;
  logic [prgate_pkg::TOKEN_W-1:0] refill_q;
  logic                           in_ready;

  // Configuration registers, always ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q         <= '0;
      check_dict_q    <= 1'b0;
      dict_q          <= '0;
      check_content_q <= 1'b0;
      content_q       <= '0;
      burst_q         <= prgate_pkg::BURST_RESET;
      refill_q        <= prgate_pkg::REFILL_RESET;
    end else if (cfg_valid_i) begin
      unique case (prgate_pkg::cfg_idx_e'(cfg_index_i))
        prgate_pkg::CFG_PROTOCOL:      proto_q <= cfg_data_i[prgate_pkg::PROTO_W-1:0];
        prgate_pkg::CFG_CHECK_DICT:    check_dict_q <= cfg_data_i[0];
        prgate_pkg::CFG_DICT:          dict_q <= cfg_data_i[prgate_pkg::DICT_W-1:0];
        prgate_pkg::CFG_CHECK_CONTENT: check_content_q <= cfg_data_i[0];
        prgate_pkg::CFG_CONTENT:       content_q <= cfg_data_i[prgate_pkg::HASH_W-1:0];
        prgate_pkg::CFG_BURST:         burst_q <= cfg_data_i[prgate_pkg::TOKEN_W-1:0];
        prgate_pkg::CFG_REFILL:        refill_q <= cfg_data_i[prgate_pkg::TOKEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o         = 1'b1;
  assign bucket_cfg_o.burst  = burst_q;
  assign bucket_cfg_o.refill = refill_q;

  // Connection reset first, then header checks in priority order; survivors go to the bucket and window
  always_comb begin
    item_o.peer    = peer_id_i;
    item_o.seq     = seq_number_i;
    item_o.now     = now_tick_i;
    item_o.op      = prgate_pkg::OP_PACKET;
    item_o.verdict = prgate_pkg::VERDICT_OK;
    priority if (action_i == prgate_pkg::ACTION_RESET) begin
      item_o.op = prgate_pkg::OP_RESET;
    end else if (pkt_protocol_i != proto_q) begin
      item_o.op      = prgate_pkg::OP_VERDICT;
      item_o.verdict = prgate_pkg::VERDICT_PROTOCOL;
    end else if (check_dict_q && (pkt_dictionary_i != dict_q)) begin
      item_o.op      = prgate_pkg::OP_VERDICT;
      item_o.verdict = prgate_pkg::VERDICT_DICT;
    end else if (check_content_q && (pkt_content_hash_i != content_q)) begin
      item_o.op      = prgate_pkg::OP_VERDICT;
      item_o.verdict = prgate_pkg::VERDICT_CONTENT;
    end else if (seq_number_i == '0) begin
      item_o.op      = prgate_pkg::OP_VERDICT;
      item_o.verdict = prgate_pkg::VERDICT_MALFORMED;
    end else begin
      item_o.op = prgate_pkg::OP_PACKET;
    end
  end

  // No transactions while the state store is being cleared
  assign in_ready   = !full_i && !clearing_i;
  assign in_ready_o = in_ready;
  assign push_o     = in_valid_i && in_ready;

endmodule

// File: hdl/prgate_back.sv
module prgate_back #(
  parameter int unsigned PEER_COUNT  = prgate_pkg::PEER_COUNT_DEFAULT,
  parameter int unsigned WINDOW_BITS = prgate_pkg::WINDOW_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  prgate_pkg::bucket_cfg_t           cfg_i,
  input  logic                              empty_i,
  input  prgate_pkg::gate_item_t            item_i,
  output logic                              pop_o,
  output logic                              clearing_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [prgate_pkg::VERDICT_W-1:0]  verdict_o
);

  localparam int unsigned PEER_W    = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;
  localparam int unsigned NUM_IDS   = 2 ** prgate_pkg::PEER_ID_W;
  localparam int unsigned WIN_IDX_W = $clog2(WINDOW_BITS);
  localparam int unsigned TOKEN_W   = prgate_pkg::TOKEN_W;
  localparam int unsigned TICK_W    = prgate_pkg::TICK_W;
  localparam int unsigned SEQ_W     = prgate_pkg::SEQ_W;
  localparam int unsigned PROD_W    = prgate_pkg::PROD_W;
  localparam int unsigned SUM_W     = PROD_W + 1;
  // entry layout, MSB first: live, tokens, last tick, top seq, window
  localparam int unsigned TOP_LSB   = WINDOW_BITS;
  localparam int unsigned LAST_LSB  = TOP_LSB + SEQ_W;
  localparam int unsigned TOK_LSB   = LAST_LSB + TICK_W;
  localparam int unsigned ENTRY_W   = TOK_LSB + TOKEN_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ELAP,
    S_MUL,
    S_UPD
  } state_e;

  state_e                  state_q, state_d;
  logic [PEER_W-1:0]       clr_q, clr_d;
  logic [PEER_W-1:0]       addr_q, addr_d;
  prgate_pkg::gate_item_t  item_q, item_d;
  logic [TICK_W-1:0]       elapsed_q, elapsed_d;
  logic [TOKEN_W-1:0]      tok_q, tok_d;
  logic [SEQ_W-1:0]        top_q, top_d;
  logic [WINDOW_BITS-1:0]  win_q, win_d;
  logic                    fresh_q, fresh_d;
  logic                    newer_q, newer_d;
  logic [SEQ_W-1:0]        diff_q, diff_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic [SEQ_W-1:0]        top_new_q, top_new_d;
  logic [WINDOW_BITS-1:0]  win_new_q, win_new_d;
  prgate_pkg::verdict_e    wverdict_q, wverdict_d;
  logic                    out_valid_q, out_valid_d;
  prgate_pkg::verdict_e    verdict_q, verdict_d;

  logic [PEER_W-1:0]       peer_map [NUM_IDS];
  logic                    ram_we, ram_re;
  logic [PEER_W-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
  logic                    rd_live;
  logic [TOKEN_W-1:0]      rd_tok;
  logic [TICK_W-1:0]       rd_last;
  logic [SEQ_W-1:0]        rd_top;
  logic [WINDOW_BITS-1:0]  rd_win;
  logic [TICK_W-1:0]       eff_last;
  logic [SUM_W-1:0]        sum;
  logic [TOKEN_W-1:0]      clamped;
  logic                    bucket_ok;
  logic                    out_free;
  logic [WIN_IDX_W-1:0]    bit_idx;
  logic                    beyond_win;

  // Peer number folded onto the entry count
  for (genvar g = 0; g < NUM_IDS; g++) begin : g_peer_map
    localparam int unsigned Slot = g % PEER_COUNT;
    assign peer_map[g] = PEER_W'(Slot);
  end

  // Per-peer state store
  prgate_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PEER_COUNT)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_live = ram_rdata[ENTRY_W-1];
  assign rd_tok  = ram_rdata[TOK_LSB +: TOKEN_W];
  assign rd_last = ram_rdata[LAST_LSB +: TICK_W];
  assign rd_top  = ram_rdata[TOP_LSB +: SEQ_W];
  assign rd_win  = ram_rdata[0 +: WINDOW_BITS];

  // Bucket refill with saturation at burst
  assign sum       = SUM_W'(tok_q) + SUM_W'(prod_q);
  assign clamped   = (sum > SUM_W'(cfg_i.burst)) ? cfg_i.burst : sum[TOKEN_W-1:0];
  assign bucket_ok = (clamped >= prgate_pkg::ONE_TOKEN);
  assign out_free  = !out_valid_q || out_ready_i;
  assign bit_idx   = diff_q[WIN_IDX_W-1:0];
  assign beyond_win = (diff_q >= SEQ_W'(WINDOW_BITS));
  assign eff_last  = rd_live ? rd_last : item_q.now;

  // Sequencer: clear pass, then read, elapsed, multiply, write back; rejects and resets go from read to write back
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    item_d      = item_q;
    elapsed_d   = elapsed_q;
    tok_d       = tok_q;
    top_d       = top_q;
    win_d       = win_q;
    fresh_d     = fresh_q;
    newer_d     = newer_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    top_new_d   = top_new_q;
    win_new_d   = win_new_q;
    wverdict_d  = wverdict_q;
    out_valid_d = out_valid_q;
    verdict_d   = verdict_q;
    pop_o       = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = peer_map[item_i.peer];
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == PEER_W'(PEER_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          ram_re  = 1'b1;
          item_d  = item_i;
          addr_d  = peer_map[item_i.peer];
          state_d = (item_i.op == prgate_pkg::OP_PACKET) ? S_ELAP : S_UPD;
        end
      end
      S_ELAP: begin
        // a peer seen for the first time starts full at the current tick
        elapsed_d = (item_q.now > eff_last) ? (item_q.now - eff_last) : '0;
        tok_d     = rd_live ? rd_tok : cfg_i.burst;
        top_d     = rd_top;
        win_d     = rd_win;
        fresh_d   = (rd_top == '0);
        newer_d   = (item_q.seq > rd_top);
        diff_d    = (item_q.seq > rd_top) ? (item_q.seq - rd_top) : (rd_top - item_q.seq);
        state_d   = S_MUL;
      end
      S_MUL: begin
        prod_d     = elapsed_q * cfg_i.refill;
        top_new_d  = top_q;
        win_new_d  = win_q;
        wverdict_d = prgate_pkg::VERDICT_OK;
        // replay window
        if (fresh_q) begin
          top_new_d = item_q.seq;
          win_new_d = WINDOW_BITS'(1);
        end else if (newer_q) begin
          top_new_d = item_q.seq;
          if (beyond_win) begin
            win_new_d = WINDOW_BITS'(1);
          end else begin
            win_new_d = (win_q << bit_idx) | WINDOW_BITS'(1);
          end
        end else if (beyond_win) begin
          wverdict_d = prgate_pkg::VERDICT_TOO_OLD;
        end else if (win_q[bit_idx]) begin
          wverdict_d = prgate_pkg::VERDICT_DUP;
        end else begin
          win_new_d = win_q | (WINDOW_BITS'(1) << bit_idx);
        end
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          unique case (item_q.op)
            prgate_pkg::OP_RESET: begin
              ram_we    = 1'b1;
              ram_wdata = '0;
              verdict_d = prgate_pkg::VERDICT_OK;
            end
            prgate_pkg::OP_PACKET: begin
              ram_we = 1'b1;
              if (!bucket_ok) begin
                ram_wdata = {1'b1, clamped, item_q.now, top_q, win_q};
                verdict_d = prgate_pkg::VERDICT_RATE;
              end else begin
                ram_wdata = {1'b1, clamped - prgate_pkg::ONE_TOKEN, item_q.now,
                             top_new_q, win_new_q};
                verdict_d = wverdict_q;
              end
            end
            default: begin
              verdict_d = item_q.verdict;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      addr_q      <= '0;
      item_q      <= '0;
      elapsed_q   <= '0;
      tok_q       <= '0;
      top_q       <= '0;
      win_q       <= '0;
      fresh_q     <= 1'b0;
      newer_q     <= 1'b0;
      diff_q      <= '0;
      prod_q      <= '0;
      top_new_q   <= '0;
      win_new_q   <= '0;
      wverdict_q  <= prgate_pkg::VERDICT_OK;
      out_valid_q <= 1'b0;
      verdict_q   <= prgate_pkg::VERDICT_OK;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      addr_q      <= addr_d;
      item_q      <= item_d;
      elapsed_q   <= elapsed_d;
      tok_q       <= tok_d;
      top_q       <= top_d;
      win_q       <= win_d;
      fresh_q     <= fresh_d;
      newer_q     <= newer_d;
      diff_q      <= diff_d;
      prod_q      <= prod_d;
      top_new_q   <= top_new_d;
      win_new_q   <= win_new_d;
      wverdict_q  <= wverdict_d;
      out_valid_q <= out_valid_d;
      verdict_q   <= verdict_d;
    end
  end

  assign clearing_o  = (state_q == S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  // Nothing leaves the queue while the store is being cleared
  a_clear_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !pop_o)
    else $error("queue popped during clear pass");

  // The store is written only by the clear pass or the write-back step
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == S_CLEAR) || (state_q == S_UPD)))
    else $error("state store written outside clear or write-back");

  // The multiply step is followed by the write-back step in the next cycle
  a_mul_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> (state_q == S_UPD))
    else $error("multiply step not followed by write-back");

  // A result only appears out of the write-back step
  a_result_from_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_UPD))
    else $error("result raised outside write-back");

endmodule

// File: hdl/packet_rate_and_replay_gate_unit.sv
// Path: a packet that passes the header checks gives its verdict after the read, elapsed,
//   multiply and write-back steps; a header reject or a connection reset skips elapsed and multiply.
// Handling: one transaction at a time, set by the per-peer read-modify-write through the
//   single state RAM and its multiply step; the next is not read until a verdict is written.
// Reset: configuration returns to defaults; a clearing pass then zeroes the peer store one
//   entry at a time, with in_ready_o low until it ends.
module packet_rate_and_replay_gate_unit #(
  parameter int unsigned PEER_COUNT  = prgate_pkg::PEER_COUNT_DEFAULT,
  parameter int unsigned WINDOW_BITS = prgate_pkg::WINDOW_BITS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // packet channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [prgate_pkg::PEER_ID_W-1:0]    peer_id_i,
  input  logic [prgate_pkg::PROTO_W-1:0]      pkt_protocol_i,
  input  logic [prgate_pkg::DICT_W-1:0]       pkt_dictionary_i,
  input  logic [prgate_pkg::HASH_W-1:0]       pkt_content_hash_i,
  input  logic [prgate_pkg::SEQ_W-1:0]        seq_number_i,
  input  logic [prgate_pkg::TICK_W-1:0]       now_tick_i,
  // verdict channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [prgate_pkg::VERDICT_W-1:0]    verdict_o,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [prgate_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [prgate_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  prgate_pkg::gate_item_t  push_item;
  prgate_pkg::gate_item_t  head_item;
  prgate_pkg::bucket_cfg_t bucket_cfg;
  logic                    push;
  logic                    pop;
  logic                    full;
  logic                    empty;
  logic                    clearing;

  // Classifier and configuration registers
  prgate_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .peer_id_i          (peer_id_i),
    .pkt_protocol_i     (pkt_protocol_i),
    .pkt_dictionary_i   (pkt_dictionary_i),
    .pkt_content_hash_i (pkt_content_hash_i),
    .seq_number_i       (seq_number_i),
    .now_tick_i         (now_tick_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .clearing_i         (clearing),
    .full_i             (full),
    .push_o             (push),
    .item_o             (push_item),
    .bucket_cfg_o       (bucket_cfg)
  );

  // Decoupling queue
  prgate_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_item),
    .empty_o (empty)
  );

  // Token bucket and replay window engine
  prgate_back #(
    .PEER_COUNT  (PEER_COUNT),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (bucket_cfg),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .verdict_o   (verdict_o)
  );

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PEERS = prgate_pkg::PEER_COUNT_DEFAULT;
  localparam int unsigned WINDOW = prgate_pkg::WINDOW_BITS_DEFAULT;
  localparam int unsigned WIN_IDX_W = $clog2(WINDOW);
  localparam int unsigned LIMIT = 200000;

  localparam int unsigned PEER_ID_W   = prgate_pkg::PEER_ID_W;
  localparam int unsigned PROTO_W     = prgate_pkg::PROTO_W;
  localparam int unsigned DICT_W      = prgate_pkg::DICT_W;
  localparam int unsigned HASH_W      = prgate_pkg::HASH_W;
  localparam int unsigned SEQ_W       = prgate_pkg::SEQ_W;
  localparam int unsigned TICK_W      = prgate_pkg::TICK_W;
  localparam int unsigned TOKEN_W     = prgate_pkg::TOKEN_W;
  localparam int unsigned VERDICT_W   = prgate_pkg::VERDICT_W;
  localparam int unsigned CFG_INDEX_W = prgate_pkg::CFG_INDEX_W;
  localparam int unsigned CFG_DATA_W  = prgate_pkg::CFG_DATA_W;

  localparam logic [TOKEN_W-1:0] ONE_TOKEN    = prgate_pkg::ONE_TOKEN;
  localparam logic [TOKEN_W-1:0] BURST_RESET  = prgate_pkg::BURST_RESET;
  localparam logic [TOKEN_W-1:0] REFILL_RESET = prgate_pkg::REFILL_RESET;

  typedef prgate_pkg::verdict_e verdict_e;
  typedef prgate_pkg::action_e  action_e;
  typedef prgate_pkg::cfg_idx_e reg_e;

  typedef struct packed {
    action_e             action;
    logic [PEER_ID_W-1:0] peer;
    logic [PROTO_W-1:0]  proto;
    logic [DICT_W-1:0]   dict;
    logic [HASH_W-1:0]   hash;
    logic [SEQ_W-1:0]    seq;
    logic [TICK_W-1:0]   now;
  } packet_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready_o;
  packet_t drv = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  logic [VERDICT_W-1:0] verdict_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the gate's registers
  logic [PROTO_W-1:0] exp_proto = '0;
  logic chk_dict = 1'b0;
  logic [DICT_W-1:0] exp_dict = '0;
  logic chk_content = 1'b0;
  logic [HASH_W-1:0] exp_hash = '0;
  logic [TOKEN_W-1:0] bkt_burst = BURST_RESET;
  logic [TOKEN_W-1:0] bkt_refill = REFILL_RESET;

  // shadow of the per-connection store
  logic conn_active [PEERS];
  logic [TOKEN_W-1:0] conn_credit [PEERS];
  logic [TICK_W-1:0] conn_stamp [PEERS];
  logic [SEQ_W-1:0] conn_newest [PEERS];
  logic [WINDOW-1:0] conn_seen [PEERS];

  // stimulus bookkeeping
  packet_t pending [$];
  verdict_e verdict_queue [$];
  logic [SEQ_W-1:0] gen_top [PEERS];
  logic [TICK_W-1:0] gen_tick = 32'd1000;
  bit calm = 1'b0;

  int errors = 0;
  int packets_sent = 0;
  int reg_writes = 0;
  int settings_used = 0;
  int verdict_hist [8];
  int cycles = 0;
  verdict_e want;

  packet_rate_and_replay_gate_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .action_i           (drv.action),
    .peer_id_i          (drv.peer),
    .pkt_protocol_i     (drv.proto),
    .pkt_dictionary_i   (drv.dict),
    .pkt_content_hash_i (drv.hash),
    .seq_number_i       (drv.seq),
    .now_tick_i         (drv.now),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .verdict_o          (verdict_o),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // connection reset clears the entry; else header checks, token bucket, then replay window; updates the shadow store
  function automatic verdict_e predict_verdict(packet_t pk);
    logic [PEER_ID_W-1:0] p;
    logic [TICK_W-1:0] elapsed;
    logic [SEQ_W-1:0] shift;
    logic [SEQ_W-1:0] age;
    logic [63:0] sum;
    p = pk.peer;
    if (pk.action == prgate_pkg::ACTION_RESET) begin
      conn_active[p] = 1'b0;
      conn_newest[p] = '0;
      conn_seen[p] = '0;
      return prgate_pkg::VERDICT_OK;
    end
    if (pk.proto != exp_proto) return prgate_pkg::VERDICT_PROTOCOL;
    if (chk_dict && pk.dict != exp_dict) return prgate_pkg::VERDICT_DICT;
    if (chk_content && pk.hash != exp_hash) return prgate_pkg::VERDICT_CONTENT;
    if (pk.seq == '0) return prgate_pkg::VERDICT_MALFORMED;

    // bucket starts full on first use
    if (!conn_active[p]) begin
      conn_active[p] = 1'b1;
      conn_credit[p] = bkt_burst;
      conn_stamp[p] = pk.now;
    end
    elapsed = (pk.now > conn_stamp[p]) ? pk.now - conn_stamp[p] : '0;
    sum = 64'(conn_credit[p]) + 64'(elapsed) * 64'(bkt_refill);
    if (sum > 64'(bkt_burst)) sum = 64'(bkt_burst);
    conn_credit[p] = sum[TOKEN_W-1:0];
    conn_stamp[p] = pk.now;
    if (conn_credit[p] < ONE_TOKEN) return prgate_pkg::VERDICT_RATE;
    conn_credit[p] = conn_credit[p] - ONE_TOKEN;

    // replay window
    if (conn_newest[p] == '0) begin
      conn_newest[p] = pk.seq;
      conn_seen[p] = WINDOW'(1);
      return prgate_pkg::VERDICT_OK;
    end
    if (pk.seq > conn_newest[p]) begin
      shift = pk.seq - conn_newest[p];
      if (shift >= WINDOW) conn_seen[p] = WINDOW'(1);
      else conn_seen[p] = (conn_seen[p] << shift) | WINDOW'(1);
      conn_newest[p] = pk.seq;
      return prgate_pkg::VERDICT_OK;
    end
    age = conn_newest[p] - pk.seq;
    if (age >= WINDOW) return prgate_pkg::VERDICT_TOO_OLD;
    if (conn_seen[p][age[WIN_IDX_W-1:0]]) return prgate_pkg::VERDICT_DUP;
    conn_seen[p][age[WIN_IDX_W-1:0]] = 1'b1;
    return prgate_pkg::VERDICT_OK;
  endfunction

  // header that passes the current checks
  function automatic packet_t good_packet(logic [PEER_ID_W-1:0] peer, logic [SEQ_W-1:0] seq,
                                          logic [TICK_W-1:0] now);
    packet_t pk;
    pk.action = prgate_pkg::ACTION_CHECK;
    pk.peer = peer;
    pk.proto = exp_proto;
    pk.dict = chk_dict ? exp_dict : DICT_W'($urandom);
    pk.hash = chk_content ? exp_hash : {$urandom, $urandom};
    pk.seq = seq;
    pk.now = now;
    return pk;
  endfunction

  // mostly well-formed traffic on a few busy connections, with some noise
  function automatic packet_t random_packet();
    packet_t pk;
    logic [PEER_ID_W-1:0] peer;
    logic [SEQ_W-1:0] seq;
    logic [TICK_W-1:0] now;
    int pick;
    peer = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      pk.action = prgate_pkg::ACTION_RESET;
      pk.peer = peer;
      pk.proto = PROTO_W'($urandom);
      pk.dict = $urandom;
      pk.hash = {$urandom, $urandom};
      pk.seq = $urandom;
      pk.now = $urandom;
      gen_top[peer] = '0;
      return pk;
    end

    pick = $urandom_range(0, 99);
    if (pick < 45) seq = gen_top[peer] + $urandom_range(1, 3);
    else if (pick < 65) seq = gen_top[peer] - $urandom_range(0, 70);
    else if (pick < 75) seq = gen_top[peer] + $urandom_range(4, 200);
    else if (pick < 80) seq = $urandom;
    else if (pick < 83) seq = '0;
    else seq = gen_top[peer] + 1;

    // time mostly creeps forward; sometimes steps back or jumps
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      gen_tick = gen_tick + $urandom_range(0, 2);
      now = gen_tick;
    end else if (pick < 70) begin
      now = gen_tick - $urandom_range(1, 50);
    end else if (pick < 75) begin
      gen_tick = $urandom;
      now = gen_tick;
    end else begin
      gen_tick = gen_tick + $urandom_range(3, 40);
      now = gen_tick;
    end

    pk = good_packet(peer, seq, now);
    pick = $urandom_range(0, 99);
    if (pick < 5) pk.proto = pk.proto ^ PROTO_W'($urandom_range(1, 65535));
    else if (pick < 9) pk.dict = pk.dict ^ ($urandom | 32'd1);
    else if (pick < 13) pk.hash = pk.hash ^ {$urandom, $urandom | 32'd1};
    if (seq > gen_top[peer]) gen_top[peer] = seq;
    return pk;
  endfunction

  // append a packet to the driver's backlog
  task automatic enqueue(input packet_t pk);
    pending.insert(pending.size(), pk);
  endtask

  // one register write transaction; shadow follows on acceptance
  task automatic write_reg(input reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      prgate_pkg::CFG_PROTOCOL:      exp_proto = val[PROTO_W-1:0];
      prgate_pkg::CFG_CHECK_DICT:    chk_dict = val[0];
      prgate_pkg::CFG_DICT:          exp_dict = val[DICT_W-1:0];
      prgate_pkg::CFG_CHECK_CONTENT: chk_content = val[0];
      prgate_pkg::CFG_CONTENT:       exp_hash = val;
      prgate_pkg::CFG_BURST:         bkt_burst = val[TOKEN_W-1:0];
      prgate_pkg::CFG_REFILL:        bkt_refill = val[TOKEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [PROTO_W-1:0] proto, input logic cdict,
                         input logic [DICT_W-1:0] dict, input logic ccont,
                         input logic [HASH_W-1:0] hash, input logic [TOKEN_W-1:0] burst,
                         input logic [TOKEN_W-1:0] refill);
    write_reg(prgate_pkg::CFG_PROTOCOL, 64'(proto));
    write_reg(prgate_pkg::CFG_CHECK_DICT, 64'(cdict));
    write_reg(prgate_pkg::CFG_DICT, 64'(dict));
    write_reg(prgate_pkg::CFG_CHECK_CONTENT, 64'(ccont));
    write_reg(prgate_pkg::CFG_CONTENT, hash);
    write_reg(prgate_pkg::CFG_BURST, 64'(burst));
    write_reg(prgate_pkg::CFG_REFILL, 64'(refill));
    settings_used++;
  endtask

  // sender holds off until every verdict is back
  task automatic drain();
    do @(posedge clk_i);
    while (pending.size() != 0 || in_valid || verdict_queue.size() != 0);
  endtask

  task automatic random_phase(input int count);
    repeat (count) enqueue(random_packet());
    drain();
  endtask

  // packet driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        verdict_queue.insert(verdict_queue.size(), predict_verdict(drv));
        packets_sent++;
      end
      if (!in_valid || in_ready_o) begin
        if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
          drv <= pending[0];
          pending.delete(0);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (verdict_queue.size() == 0) begin
          errors++;
          $display("%0t: verdict %0d with none expected", $realtime, verdict_o);
        end else begin
          want = verdict_queue[0];
          verdict_queue.delete(0);
          if (verdict_o !== want) begin
            errors++;
            $display("%0t: verdict mismatch, expected %0d (%s), actual %0d",
                     $realtime, want, want.name(), verdict_o);
          end
        end
        if (!$isunknown(verdict_o)) verdict_hist[verdict_o]++;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < PEERS; i++) begin
      conn_active[i] = 1'b0;
      conn_credit[i] = '0;
      conn_stamp[i] = '0;
      conn_newest[i] = '0;
      conn_seen[i] = '0;
      gen_top[i] = '0;
    end
    for (int i = 0; i < 8; i++) verdict_hist[i] = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every verdict but the rate limit, with all header checks on
    set_all(16'h1234, 1'b1, 32'hDEAD_BEEF, 1'b1, 64'h0123_4567_89AB_CDEF,
            BURST_RESET, REFILL_RESET);
    enqueue(good_packet(4'd0, 32'd1, 32'd100));
    enqueue(good_packet(4'd0, 32'd1, 32'd100));
    enqueue(good_packet(4'd0, 32'd2, 32'd100));
    pending[$].proto = 16'h1235;
    enqueue(good_packet(4'd0, 32'd2, 32'd100));
    pending[$].dict = 32'hDEAD_BEEE;
    enqueue(good_packet(4'd0, 32'd2, 32'd100));
    pending[$].hash = 64'h8123_4567_89AB_CDEF;
    enqueue(good_packet(4'd0, 32'd0, 32'd100));
    // large jump, then the window edge
    enqueue(good_packet(4'd0, 32'd1000, 32'd101));
    enqueue(good_packet(4'd0, 32'd936, 32'd101));
    enqueue(good_packet(4'd0, 32'd937, 32'd101));
    enqueue(good_packet(4'd0, 32'd937, 32'd101));
    enqueue(good_packet(4'd0, 32'd1001, 32'd102));
    // top of the fields, then time going backwards
    enqueue(good_packet(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    enqueue(good_packet(4'd15, 32'd5, 32'd10));
    // connection reset, then a fresh start on it
    enqueue('{prgate_pkg::ACTION_RESET, 4'hF, 16'hFFFF, 32'hFFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pending[$].peer = 4'd0;
    enqueue(good_packet(4'd0, 32'd3, 32'd103));
    drain();

    // one-token bucket with no refill: second packet is throttled
    write_reg(prgate_pkg::CFG_BURST, 64'(ONE_TOKEN));
    write_reg(prgate_pkg::CFG_REFILL, 64'd0);
    enqueue(good_packet(4'd2, 32'd1, 32'd200));
    enqueue(good_packet(4'd2, 32'd2, 32'd200));
    enqueue(good_packet(4'd2, 32'd2, 32'd5000));
    drain();
    write_reg(prgate_pkg::CFG_REFILL, 64'hFF_FFFF);
    enqueue(good_packet(4'd2, 32'd2, 32'd5001));
    enqueue(good_packet(4'd2, 32'd3, 32'd5001));
    enqueue('{prgate_pkg::ACTION_RESET, 4'd2, 16'h0, 32'h0, 64'h0, 32'h0, 32'h0});
    enqueue(good_packet(4'd2, 32'd7, 32'd5001));
    drain();

    // all-ones settings but the dictionary check off, no idling on either side
    calm = 1'b1;
    set_all(16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
            24'hFF_FFFF, 24'hFF_FFFF);
    random_phase(80);
    calm = 1'b0;

    // tight bucket: rate limiting is common
    set_all(16'h0000, 1'b0, 32'h0, 1'b0, 64'h0, 24'h02_0000, 24'h00_2000);
    random_phase(100);

    // empty bucket that never refills
    set_all(16'h0000, 1'b1, 32'h0, 1'b0, 64'h0, 24'h00_0000, 24'h00_0000);
    random_phase(20);

    // random settings
    repeat (2) begin
      set_all(PROTO_W'($urandom), 1'($urandom), $urandom, 1'($urandom), {$urandom, $urandom},
              TOKEN_W'($urandom_range(0, 24'h30_0000)),
              TOKEN_W'($urandom_range(0, 24'h03_0000)));
      random_phase(100);
    end

    repeat (8) @(posedge clk_i);
    $display("tb_top: %0d packets, %0d register writes over %0d settings",
             packets_sent, reg_writes, settings_used);
    $display("tb_top: ok %0d proto %0d dict %0d content %0d bad %0d rate %0d old %0d dup %0d",
             verdict_hist[0], verdict_hist[1], verdict_hist[2], verdict_hist[3],
             verdict_hist[4], verdict_hist[5], verdict_hist[6], verdict_hist[7]);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
